[src/beaur_pkg.sv]
// Package for the button edge and auto-repeat unit: item types, configuration
// groups, register indexes and reset values. No dependencies.
package beaur_pkg;

  // Input item: one frame of pad state
  typedef struct packed {
    logic [15:0]        raw_buttons;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
  } in_item_t;

  // Result item: masks for one frame
  typedef struct packed {
    logic [15:0] held_buttons;
    logic [15:0] pressed_edges;
    logic [15:0] released_edges;
    logic [15:0] repeat_pulses;
  } out_item_t;

  // Settings used by the front (stick decode and remap)
  typedef struct packed {
    logic [63:0] button_remap;
    logic        stick_enable;
    logic [15:0] stick_direction_bits;
    logic [14:0] dead_zone;
  } map_cfg_t;

  // Settings used by the back (repeat timing)
  typedef struct packed {
    logic [3:0] repeat_first_wait;
    logic [3:0] rpt_ivl_init;
    logic [3:0] rpt_ivl_floor;
  } rpt_cfg_t;

  // Register indexes (byte address / 8)
  localparam logic [2:0] REG_BUTTON_REMAP   = 3'd0;
  localparam logic [2:0] REG_STICK_ENABLE   = 3'd1;
  localparam logic [2:0] REG_STICK_DIR_BITS = 3'd2;
  localparam logic [2:0] REG_DEAD_ZONE      = 3'd3;
  localparam logic [2:0] REG_FIRST_WAIT     = 3'd4;
  localparam logic [2:0] REG_DELAY_START    = 3'd5;
  localparam logic [2:0] REG_DELAY_MIN      = 3'd6;

  // Register reset values
  localparam logic [63:0] RST_BUTTON_REMAP   = 64'hFEDC_BA98_7654_3210;
  localparam logic        RST_STICK_ENABLE   = 1'b0;
  localparam logic [15:0] RST_STICK_DIR_BITS = 16'h3210;
  localparam logic [14:0] RST_DEAD_ZONE      = 15'h4000;
  localparam logic [3:0]  RST_FIRST_WAIT     = 4'd12;
  localparam logic [3:0]  RST_DELAY_START    = 4'd6;
  localparam logic [3:0]  RST_DELAY_MIN      = 4'd2;

  // Stick direction codes (nibble slot in stick_direction_bits)
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

endpackage

[src/button_edge_and_auto_repeat_unit.sv]
// Top level of the button edge and auto-repeat unit: configuration registers
// and the front, queue and back parts. Depends on beaur_pkg, beaur_front,
// beaur_queue and beaur_back.
//
// One pad frame is taken per clock cycle while full is low and gives one
// result, in order. A frame is decoded and remapped combinationally while
// push is high and is written into a two-entry queue at the edge of its
// transfer; the back end takes it once the result slot is free or drains,
// updates the per-button repeat counters and loads the result register.
// The sustained rate is one frame per cycle while the result side keeps
// popping; full rises only when the result side stops popping and the
// queue fills. Registers sit at byte addresses 8*i on a 64-bit APB-style
// port; write them only while idle.
module button_edge_and_auto_repeat_unit
  import beaur_pkg::*;
#(
  parameter int BUTTONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input frames
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  // results
  input  logic        pop,
  output logic        empty,
  output out_item_t   out_item,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  map_cfg_t    map_cfg_r;
  rpt_cfg_t    rpt_cfg_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;
  logic [15:0] front_held, q_held;
  logic        q_valid, q_pop, push_ok;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign push_ok = push && !full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_cfg_r.button_remap         <= RST_BUTTON_REMAP;
      map_cfg_r.stick_enable         <= RST_STICK_ENABLE;
      map_cfg_r.stick_direction_bits <= RST_STICK_DIR_BITS;
      map_cfg_r.dead_zone            <= RST_DEAD_ZONE;
      rpt_cfg_r.repeat_first_wait    <= RST_FIRST_WAIT;
      rpt_cfg_r.rpt_ivl_init         <= RST_DELAY_START;
      rpt_cfg_r.rpt_ivl_floor        <= RST_DELAY_MIN;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BUTTON_REMAP:   map_cfg_r.button_remap         <= pwdata;
        REG_STICK_ENABLE:   map_cfg_r.stick_enable         <= pwdata[0];
        REG_STICK_DIR_BITS: map_cfg_r.stick_direction_bits <= pwdata[15:0];
        REG_DEAD_ZONE:      map_cfg_r.dead_zone            <= pwdata[14:0];
        REG_FIRST_WAIT:     rpt_cfg_r.repeat_first_wait    <= pwdata[3:0];
        REG_DELAY_START:    rpt_cfg_r.rpt_ivl_init         <= pwdata[3:0];
        REG_DELAY_MIN:      rpt_cfg_r.rpt_ivl_floor        <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_BUTTON_REMAP:   prdata = map_cfg_r.button_remap;
      REG_STICK_ENABLE:   prdata = {63'd0, map_cfg_r.stick_enable};
      REG_STICK_DIR_BITS: prdata = {48'd0, map_cfg_r.stick_direction_bits};
      REG_DEAD_ZONE:      prdata = {49'd0, map_cfg_r.dead_zone};
      REG_FIRST_WAIT:     prdata = {60'd0, rpt_cfg_r.repeat_first_wait};
      REG_DELAY_START:    prdata = {60'd0, rpt_cfg_r.rpt_ivl_init};
      REG_DELAY_MIN:      prdata = {60'd0, rpt_cfg_r.rpt_ivl_floor};
      default:            prdata = 64'd0;
    endcase
  end

  // Front: decode and remap
  beaur_front #(.BUTTONS(BUTTONS)) u_front (
    .item (in_item),
    .cfg  (map_cfg_r),
    .held (front_held)
  );

  // Queue between front and back
  beaur_queue #(.DEPTH(2)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push_ok),
    .wr_data  (front_held),
    .full     (full),
    .rd_en    (q_pop),
    .rd_data  (q_held),
    .rd_valid (q_valid)
  );

  // Back: edges, repeat and result register
  beaur_back #(.BUTTONS(BUTTONS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (rpt_cfg_r),
    .q_valid  (q_valid),
    .q_held   (q_held),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

[src/beaur_front.sv]
// Front end: turns one input frame into the remapped held-button mask.
// Depends on beaur_pkg.
module beaur_front
  import beaur_pkg::*;
#(
  parameter int BUTTONS = 16
) (
  input  in_item_t    item,
  input  map_cfg_t    cfg,
  output logic [15:0] held
);

  localparam logic [15:0] LIVE_MASK = 16'((32'd1 << BUTTONS) - 32'd1);

  logic signed [16:0] x_e, y_e, nx_e, dz_e, ndz_e;
  logic               in_dead, y_le_x, y_le_nx;
  logic [1:0]         dir;
  logic [3:0]         dir_bit;
  logic [15:0]        stick_mask, raw;

  // Stick to direction: square dead zone, then diagonal sectors
  always_comb begin
    x_e     = {item.stick_x[15], item.stick_x};
    y_e     = {item.stick_y[15], item.stick_y};
    nx_e    = -x_e;
    dz_e    = {2'b00, cfg.dead_zone};
    ndz_e   = -dz_e;
    in_dead = (x_e >= ndz_e) && (x_e <= dz_e) && (y_e >= ndz_e) && (y_e <= dz_e);
    y_le_x  = y_e <= x_e;
    y_le_nx = y_e <= nx_e;
    if (y_le_x) begin
      dir = y_le_nx ? DIR_DOWN : DIR_RIGHT;
    end else begin
      dir = y_le_nx ? DIR_LEFT : DIR_UP;
    end
    dir_bit    = cfg.stick_direction_bits[{dir, 2'b00} +: 4];
    stick_mask = (cfg.stick_enable && !in_dead) ? (16'd1 << dir_bit) : 16'd0;
    raw        = (item.raw_buttons | stick_mask) & LIVE_MASK;
  end

  // Move each source button to its target bit
  always_comb begin
    held = 16'd0;
    for (int i = 0; i < BUTTONS; i++) begin
      if (raw[i]) begin
        held = held | (16'd1 << cfg.button_remap[4*i +: 4]);
      end
    end
    held = held & LIVE_MASK;
  end

endmodule

[src/beaur_queue.sv]
// Short queue of held masks between front and back.
// Depends on nothing but its parameter.
module beaur_queue #(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [15:0] wr_data,
  output logic        full,
  input  logic        rd_en,
  output logic [15:0] rd_data,
  output logic        rd_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [15:0]   slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full     = cnt_r == FULL_CNT;
  assign rd_valid = cnt_r != '0;
  assign rd_data  = slot_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full)) else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && !rd_valid)) else $error("queue read while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT) else $error("queue count out of range");
`endif

endmodule

[src/beaur_back.sv]
// Back end: edge detection, per-button repeat counters and the result register.
// Depends on beaur_pkg.
module beaur_back
  import beaur_pkg::*;
#(
  parameter int BUTTONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rpt_cfg_t    cfg,
  input  logic        q_valid,
  input  logic [15:0] q_held,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output out_item_t   out_item
);

  logic [15:0] prev_r;
  logic [3:0]  cnt_r [BUTTONS];
  logic [3:0]  ivl_r [BUTTONS];
  logic [3:0]  cnt_nxt [BUTTONS];
  logic [3:0]  ivl_nxt [BUTTONS];
  logic [15:0] pulse_nxt;
  out_item_t   out_r;
  logic        out_valid_r;

  // Take a held mask when the result slot is free or drains this cycle
  assign q_pop    = q_valid && (!out_valid_r || pop);
  assign empty    = !out_valid_r;
  assign out_item = out_r;

  // Repeat countdown per button
  always_comb begin
    pulse_nxt = 16'd0;
    for (int i = 0; i < BUTTONS; i++) begin
      if (q_held[i]) begin
        pulse_nxt[i] = cnt_r[i] == cfg.repeat_first_wait;
        cnt_nxt[i]   = cnt_r[i] - 4'd1;
        ivl_nxt[i]   = ivl_r[i];
        if (cnt_r[i] == 4'd1) begin
          pulse_nxt[i] = 1'b1;
          cnt_nxt[i]   = ivl_r[i];
          ivl_nxt[i]   = (ivl_r[i] <= cfg.rpt_ivl_floor) ? cfg.rpt_ivl_floor
                                                          : ivl_r[i] - 4'd1;
        end
      end else begin
        cnt_nxt[i] = cfg.repeat_first_wait;
        ivl_nxt[i] = cfg.rpt_ivl_init;
      end
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= 16'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < BUTTONS; i++) begin
        cnt_r[i] <= RST_FIRST_WAIT;
        ivl_r[i] <= RST_DELAY_START;
      end
    end else begin
      if (q_pop) begin
        prev_r      <= q_held;
        out_valid_r <= 1'b1;
        for (int i = 0; i < BUTTONS; i++) begin
          cnt_r[i] <= cnt_nxt[i];
          ivl_r[i] <= ivl_nxt[i];
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r.held_buttons   <= q_held;
      out_r.pressed_edges  <= q_held & ~prev_r;
      out_r.released_edges <= prev_r & ~q_held;
      out_r.repeat_pulses  <= pulse_nxt;
    end
  end

`ifndef SYNTHESIS
  a_take_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_valid_r || pop)) else $error("result slot overwritten");
  a_pulse_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.repeat_pulses & ~out_r.held_buttons) == 16'd0))
    else $error("repeat pulse on a button not held");
  a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.pressed_edges & ~out_r.held_buttons) == 16'd0 &&
                     (out_r.released_edges & out_r.held_buttons) == 16'd0))
    else $error("edge masks disagree with held mask");
  a_press_pulses: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> ((out_r.held_buttons == $past(q_held)) &&
               (out_r.pressed_edges == ($past(q_held) & ~$past(prev_r)))))
    else $error("result does not match the taken frame");
`endif

endmodule
